// File: design/bbs_pkg.sv
// bbs_pkg: payload types, register indexes and reset values for the
// ranged blum blum shub generator; no dependencies
package bbs_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef struct packed {
    logic [FIELD_W-1:0] lower_bound;
    logic [FIELD_W-1:0] upper_bound;
  } bbs_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] number;
    logic               range_error;
  } bbs_out_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MODE = 2'd2;

  localparam logic [FIELD_W-1:0] MODULUS_RST = 32'd61329181;
  localparam logic [FIELD_W-1:0] SEED_RST    = 32'd123456;

endpackage

// File: design/bbs_ranged_random.sv
// bbs_ranged_random: ranged blum blum shub generator, top level
// depends on bbs_pkg and bbs_sqr
//
// Each request draws k = bit length of (upper_bound - lower_bound) bits, one
// modular squaring of the state per bit unless the modulus is zero, then
// folds the value into the range with one compare and subtract and adds
// lower_bound. The bit-serial squaring unit handles one multiplier bit per
// cycle; a squaring whose input is not below the modulus, as after a seed or
// modulus write, first runs a pre-reduction. A unit range draws no bits and
// an inverted range skips the draw and flags range_error. One request is
// worked at a time; a new one is taken as soon as the previous result sits in
// the output register, even while that result is stalled.
module bbs_ranged_random
  import bbs_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FIELD_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bbs_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bbs_out_t             out_data_o
);

  localparam int unsigned W = WORD_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_SQR,
    ST_BIT,
    ST_FIN,
    ST_OUT
  } state_e;

  state_e       state_q;
  logic [W-1:0] mod_q;
  logic         bit_mode_q;
  logic [W-1:0] x_q;
  logic [W-1:0] lo_q;
  logic [W-1:0] d_q;
  logic [W:0]   rng_q;
  logic [W-1:0] v_q;
  logic         err_q;
  logic         out_valid_q;
  bbs_out_t     out_q;

  logic [W-1:0] in_lo;
  logic [W-1:0] in_hi;
  logic [W-1:0] in_d;
  logic         in_take;
  logic         sqr_start;
  logic         sqr_done;
  logic [W-1:0] sqr_res;
  logic         draw_bit;
  logic [W:0]   v_sub;
  logic [W-1:0] sum;
  logic         out_free;

  assign in_lo   = in_data_i.lower_bound[W-1:0];
  assign in_hi   = in_data_i.upper_bound[W-1:0];
  assign in_d    = in_hi - in_lo;
  assign in_take = in_valid_i && !in_stall_o;

  assign sqr_start = (state_q == ST_NEXT) && (d_q != '0) && (mod_q != '0);
  assign draw_bit  = bit_mode_q ? ^x_q : x_q[0];
  assign v_sub     = {1'b0, v_q} - rng_q;
  assign sum       = v_q + lo_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  bbs_sqr #(
    .WORD_WIDTH(W)
  ) u_sqr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqr_start),
    .x_i    (x_q),
    .n_i    (mod_q),
    .done_o (sqr_done),
    .res_o  (sqr_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mod_q       <= MODULUS_RST[W-1:0];
      bit_mode_q  <= 1'b0;
      x_q         <= SEED_RST[W-1:0];
      lo_q        <= '0;
      d_q         <= '0;
      rng_q       <= '0;
      v_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            lo_q  <= in_lo;
            d_q   <= in_d;
            rng_q <= {1'b0, in_d} + 1'b1;
            v_q   <= '0;
            err_q <= (in_lo > in_hi);
            state_q <= (in_lo > in_hi) ? ST_OUT : ST_NEXT;
          end
        end
        ST_NEXT: begin
          // one squaring per significant bit of upper - lower if mod_q != 0
          if (d_q == '0) begin
            state_q <= ST_FIN;
          end else if (mod_q == '0) begin
            state_q <= ST_BIT;
          end else begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (sqr_done) begin
            x_q     <= sqr_res;
            state_q <= ST_BIT;
          end
        end
        ST_BIT: begin
          v_q     <= {v_q[W-2:0], draw_bit};
          d_q     <= {1'b0, d_q[W-1:1]};
          state_q <= ST_NEXT;
        end
        ST_FIN: begin
          // v is below twice the range, so one subtract folds it
          if (!v_sub[W]) begin
            v_q <= v_sub[W-1:0];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_q.number      <= err_q ? '0 : FIELD_W'(sum);
            out_q.range_error <= err_q;
            out_valid_q       <= 1'b1;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODULUS:  mod_q      <= cfg_data_i[W-1:0];
          CFG_SEED:     x_q        <= cfg_data_i[W-1:0];
          CFG_BIT_MODE: bit_mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_sqr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqr_done |-> (state_q == ST_SQR))
    else $error("squaring unit finished outside of a squaring wait");

  a_sqr_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sqr_done && (mod_q != '0)) |-> (sqr_res < mod_q))
    else $error("squaring result not reduced below the modulus");

  a_fold_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && !err_q) |-> ({2'b00, v_q} < {rng_q, 1'b0}))
    else $error("drawn value needs more than one fold into the range");

  a_err_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && (in_lo > in_hi)) |=> (state_q == ST_OUT) && $stable(x_q))
    else $error("inverted range started a draw");

endmodule

// File: design/bbs_sqr.sv
// bbs_sqr: bit-serial modular squaring, res = x*x mod n
// optional restoring pre-reduction when x >= n; uses bbs_pkg only for style
module bbs_sqr
  import bbs_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_WIDTH-1:0] x_i,
  input  logic [WORD_WIDTH-1:0] n_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] res_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RED,
    SQ_MUL
  } sq_state_e;

  sq_state_e      state_q;
  logic [W-1:0]   xs_q;
  logic [W-1:0]   mb_q;
  logic [W-1:0]   t_q;
  logic [W-1:0]   r_q;
  logic [W-1:0]   res_q;
  logic [CW-1:0]  cnt_q;
  logic           done_q;

  logic [W:0]     red_sh;
  logic [W+1:0]   red_diff;
  logic [W-1:0]   red_next;
  logic [W:0]     dbl;
  logic [W+1:0]   dbl_diff;
  logic [W-1:0]   t_next;
  logic [W:0]     acc_sum;
  logic [W+1:0]   acc_diff;
  logic [W-1:0]   r_next;

  // restoring reduction, one bit of x per cycle from the msb
  assign red_sh   = {r_q, mb_q[W-1]};
  assign red_diff = {1'b0, red_sh} - {2'b00, n_i};
  assign red_next = red_diff[W+1] ? red_sh[W-1:0] : red_diff[W-1:0];

  // t walks through a*2^i mod n while r accumulates the selected terms
  assign dbl      = {t_q, 1'b0};
  assign dbl_diff = {1'b0, dbl} - {2'b00, n_i};
  assign t_next   = dbl_diff[W+1] ? dbl[W-1:0] : dbl_diff[W-1:0];

  assign acc_sum  = {1'b0, r_q} + {1'b0, t_q};
  assign acc_diff = {1'b0, acc_sum} - {2'b00, n_i};
  assign r_next   = !mb_q[0]     ? r_q :
                    acc_diff[W+1] ? acc_sum[W-1:0] : acc_diff[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
      xs_q    <= '0;
      mb_q    <= '0;
      t_q     <= '0;
      r_q     <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            xs_q  <= x_i;
            mb_q  <= x_i;
            t_q   <= x_i;
            r_q   <= '0;
            cnt_q <= '0;
            state_q <= (x_i >= n_i) ? SQ_RED : SQ_MUL;
          end
        end
        SQ_RED: begin
          mb_q  <= {mb_q[W-2:0], 1'b0};
          r_q   <= red_next;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            t_q     <= red_next;
            r_q     <= '0;
            mb_q    <= xs_q;
            cnt_q   <= '0;
            state_q <= SQ_MUL;
          end
        end
        SQ_MUL: begin
          mb_q  <= {1'b0, mb_q[W-1:1]};
          t_q   <= t_next;
          r_q   <= r_next;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            res_q   <= r_next;
            done_q  <= 1'b1;
            state_q <= SQ_IDLE;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: verif/bbs_ranged_random_tb.sv
`timescale 1ns / 100ps
// bbs_ranged_random_tb: self-checking bench for the ranged blum blum shub generator
// depends on bbs_pkg and the bbs_ranged_random rtl; predicts each draw itself

module bbs_ranged_random_tb;
  import bbs_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 1300;
  localparam int unsigned PHASE_ITEMS  = 87;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned NUM_ROWS     = 18;

  typedef struct packed {
    logic [FIELD_W-1:0] lower;
    logic [FIELD_W-1:0] upper;
    logic               known;
    logic [FIELD_W-1:0] number;
    logic               range_error;
  } directed_row_t;

  typedef struct packed {
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] seed;
    logic               mode;
    logic               load_seed;
  } setting_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_MODULUS;
  logic [FIELD_W-1:0]   cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  bbs_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  bbs_out_t             out_data_o;

  // predictor copy of the generator and its registers
  logic [FIELD_W-1:0] gen_state;
  logic [FIELD_W-1:0] gen_modulus;
  logic               gen_parity;

  bbs_out_t    draws_due[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned inverted_sent = 0;
  int unsigned unit_sent = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          gaps_on = 1'b1;

  // unit, inverted, extreme and small ranges at the reset settings
  directed_row_t directed_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
    '{32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_0064, 32'h0000_006B, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_0064, 32'h0000_006C, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 32'h0000_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{32'hA5A5_0000, 32'hA5A5_00FF, 1'b0, 32'h0000_0000, 1'b0},
    '{32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0}
  };

  bbs_ranged_random #(
    .WORD_WIDTH(FIELD_W)
  ) uut (
    .*
  );

  always #2 clk_i = ~clk_i;

  // squaring per bit if modulus != 0, bits packed msb first, folded into the range
  function automatic bbs_out_t draw_number(input bbs_in_t req);
    logic [63:0] span;
    logic [63:0] acc;
    logic [63:0] sq;
    int unsigned nbits;
    bbs_out_t    res;
    res = '0;
    if (req.lower_bound > req.upper_bound) begin
      res.range_error = 1'b1;
      return res;
    end
    span  = {32'd0, req.upper_bound} - {32'd0, req.lower_bound} + 64'd1;
    nbits = 0;
    while ((64'd1 << nbits) < span) nbits++;
    acc = '0;
    sq  = {32'd0, gen_state};
    for (int i = 0; i < nbits; i++) begin
      if (gen_modulus != '0) sq = (sq * sq) % {32'd0, gen_modulus};
      acc = {acc[62:0], (gen_parity ? ^sq[31:0] : sq[0])};
    end
    gen_state  = sq[31:0];
    acc        = (acc % span) + {32'd0, req.lower_bound};
    res.number = acc[31:0];
    return res;
  endfunction

  function automatic bbs_in_t random_request();
    bbs_in_t            req;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] span;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    a    = $urandom;
    b    = $urandom;
    if (pick < 8) begin
      req.lower_bound = (a > b) ? a : b;
      req.upper_bound = (a > b) ? b : a;
    end else if (pick < 14) begin
      req.lower_bound = a;
      req.upper_bound = a;
    end else if (pick < 18) begin
      // wide ranges are slow, so they stay rare
      req.lower_bound = (a > b) ? b : a;
      req.upper_bound = (a > b) ? a : b;
    end else begin
      span = b & ((32'd1 << $urandom_range(0, 10)) - 32'd1);
      req.lower_bound = a;
      req.upper_bound = a + span;
    end
    return req;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MODULUS:  gen_modulus = value;
      CFG_SEED:     gen_state = value;
      CFG_BIT_MODE: gen_parity = value[0];
      default: ;
    endcase
  endtask

  task automatic send_request(input bbs_in_t req, input logic known, input bbs_out_t typed);
    bbs_out_t    due;
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 29) == 0) gaps_on = !gaps_on;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    due = draw_number(req);
    if (known) due = typed;
    draws_due.push_back(due);
    requests_sent++;
    if (req.lower_bound > req.upper_bound) inverted_sent++;
    else if (req.lower_bound == req.upper_bound) unit_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (draws_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    setting_t phases [NUM_PHASES];
    bbs_out_t typed;
    bbs_in_t  req;
    gen_modulus = MODULUS_RST;
    gen_state   = SEED_RST;
    gen_parity  = 1'b0;
    phases[0] = '{MODULUS_RST, SEED_RST, 1'b0, 1'b0};
    // smallest modulus, seed above it gets reduced by the first squaring
    phases[1] = '{32'd3, 32'hFFFF_FFFE, 1'b1, 1'b1};
    phases[2] = '{32'hFFFF_FFFF, 32'h1234_5679, 1'b0, 1'b1};
    // no seed write: the state carries over and may exceed the new modulus
    phases[3] = '{32'd272953, 32'h0, 1'b1, 1'b0};
    phases[4].modulus   = $urandom_range(32'hFFFF_FFFF, 32'd3);
    phases[4].seed      = 32'h0;
    phases[4].mode      = 1'b0;
    phases[4].load_seed = 1'b1;
    phases[5].modulus   = MODULUS_RST;
    phases[5].seed      = $urandom;
    phases[5].mode      = 1'b1;
    phases[5].load_seed = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      req.lower_bound   = directed_rows[i].lower;
      req.upper_bound   = directed_rows[i].upper;
      typed.number      = directed_rows[i].number;
      typed.range_error = directed_rows[i].range_error;
      send_request(req, directed_rows[i].known, typed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      if (p != 0) begin
        write_reg(CFG_MODULUS, phases[p].modulus);
        if (phases[p].load_seed) write_reg(CFG_SEED, phases[p].seed);
        write_reg(CFG_BIT_MODE, {{(FIELD_W-1){1'b0}}, phases[p].mode});
        cfg_we_i <= 1'b0;
      end
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("ran %0d requests (%0d inverted, %0d unit range), %0d results checked",
             requests_sent, inverted_sent, unit_sent, results_seen);
    $display("over %0d register settings with both bit modes, extremes of modulus and seed",
             NUM_PHASES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_checker
    int unsigned stall_left;
    bit          bursts_on;
    bit          held;
    bbs_out_t    due;
    stall_left = 0;
    bursts_on  = 1'b1;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (draws_due.size() == 0) begin
          $error("unexpected result: number %h range_error %b",
                 out_data_o.number, out_data_o.range_error);
          mismatches++;
        end else begin
          due = draws_due.pop_front();
          if (out_data_o.number !== due.number) begin
            $error("number: expected %h, got %h", due.number, out_data_o.number);
            mismatches++;
          end
          if (out_data_o.range_error !== due.range_error) begin
            $error("range_error: expected %b, got %b", due.range_error,
                   out_data_o.range_error);
            mismatches++;
          end
        end
      end
      if (!quiet && $urandom_range(0, 149) == 0) bursts_on = !bursts_on;
      // one long hold so the block backs up and stalls its input
      if (stall_left != 0) stall_left--;
      else if (!quiet && !held && results_seen >= 40) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (!quiet && bursts_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $error("no transfer for %0d cycles, %0d draws outstanding", IDLE_LIMIT, draws_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
